[sv/size_class_block_allocator_unit_assert.svh]
// ----------------------------------------------------------------------------
// size_class_block_allocator_unit_assert.svh
// Assertion macros for the allocator RTL, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent true means consequent true in the same cycle
`define SCBA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// antecedent true means consequent true in the next cycle
`define SCBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next cycle");

// condition never true
`define SCBA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: forbidden condition");

`else

`define SCBA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define SCBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define SCBA_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[sv/scba_pkg.sv]
// ----------------------------------------------------------------------------
// scba_pkg
// Constants, codes and types of the size class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

	// geometry
	localparam int NUM_CLASSES      = 4;
	localparam int CLS_W            = 2;
	localparam int IDX_W            = 10;
	localparam int CNT_W            = 11;
	localparam int BLOCKS_PER_CLASS = 1024;
	localparam int WORD_W           = 64;
	localparam int BIT_W            = $clog2(WORD_W);
	localparam int WORDS_PER_CLASS  = BLOCKS_PER_CLASS / WORD_W;
	localparam int WSEL_W           = $clog2(WORDS_PER_CLASS);
	localparam int RAM_DEPTH        = NUM_CLASSES * WORDS_PER_CLASS;
	localparam int RAM_AW           = $clog2(RAM_DEPTH);
	localparam int NWORD_W          = WSEL_W + 1;

	// find-first-zero grouping
	localparam int GRP_W   = 8;
	localparam int NGRP    = WORD_W / GRP_W;
	localparam int GRP_BW  = $clog2(GRP_W);
	localparam int NGRP_BW = BIT_W - GRP_BW;

	// stream widths
	localparam int SIZE_W = 32;
	localparam int IN_W   = 48;
	localparam int OUT_W  = 16;

	// class upper bounds in bytes (exclusive)
	localparam logic [SIZE_W-1:0] BOUND_A = 32'd64;
	localparam logic [SIZE_W-1:0] BOUND_B = 32'd128;
	localparam logic [SIZE_W-1:0] BOUND_C = 32'd256;
	localparam logic [SIZE_W-1:0] BOUND_D = 32'd512;

	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);
	localparam logic [CNT_W-1:0] BLOCK_LIMIT = CNT_W'(BLOCKS_PER_CLASS);

	localparam logic [CLS_W-1:0] CLASS_A    = 2'd0;
	localparam logic [CLS_W-1:0] CLASS_B    = 2'd1;
	localparam logic [CLS_W-1:0] CLASS_C    = 2'd2;
	localparam logic [CLS_W-1:0] CLASS_D    = 2'd3;
	localparam logic [CLS_W-1:0] CLASS_LAST = CLASS_D;

	// request kind on the input tuser
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_GRANT     = 2'd0,
		ST_EXTERNAL  = 2'd1,
		ST_EXHAUSTED = 2'd2,
		ST_FREED     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_FREE_RD,
		S_FREE_WR
	} state_t;

	// result of the find-first-zero unit
	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} ffs_t;

endpackage

[sv/size_class_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// size_class_block_allocator_unit
// Bitmap allocator over four block size classes of 64, 128, 256, 512 bytes.
// ----------------------------------------------------------------------------
// Requests come in on the s_ stream, one transaction each; tuser says alloc
// (0) or free (1). Every request gives exactly one result on the m_ stream,
// with the status on tuser and the class and index on tdata.
// Used flags sit in a 64 x 64-bit RAM, one word per 64 blocks; a full bit
// and a written bit per word live in flops. An allocation walks the classes
// from the smallest that fits: the scan state picks the first non-full
// word of the class with the shared find-first-zero unit and reads it, the
// next cycle picks the free bit with the same unit and writes the word back.
// External requests are answered from the idle state, frees pass a read and
// a write state, and allocations pass a scan state per class tried plus a
// pick state per class whose word summary shows a non-full word.
// One request is in work at a time; s_tready is low while busy and while a
// result waits in the output register, so a stalled receiver holds input.
// The next request can be taken in the cycle after the result is taken.
// Reset clears all flags at once (word written bits cleared), counts go to
// 1024, and the output is empty; no clearing pass is needed. The user writes
// class counts via cfg_we/cfg_index/cfg_data only while idle (unenforced).
// ----------------------------------------------------------------------------
`include "size_class_block_allocator_unit_assert.svh"

module size_class_block_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [scba_pkg::CLS_W-1:0]    cfg_index,
	input  logic [scba_pkg::CNT_W-1:0]    cfg_data,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [31:0] req_size, [33:32] free_class, [43:34] free_index, zero fill
	input  logic [scba_pkg::IN_W-1:0]     s_tdata,
	// [0] mode
	input  logic                          s_tuser,
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [1:0] grant_class, [11:2] grant_index, zero fill
	output logic [scba_pkg::OUT_W-1:0]    m_tdata,
	// [1:0] status
	output logic [1:0]                    m_tuser
);

	localparam int CLS_W  = scba_pkg::CLS_W;
	localparam int IDX_W  = scba_pkg::IDX_W;
	localparam int CNT_W  = scba_pkg::CNT_W;
	localparam int WORD_W = scba_pkg::WORD_W;
	localparam int BIT_W  = scba_pkg::BIT_W;
	localparam int WSEL_W = scba_pkg::WSEL_W;
	localparam int RAM_AW = scba_pkg::RAM_AW;
	localparam int NCLS   = scba_pkg::NUM_CLASSES;
	localparam int WPC    = scba_pkg::WORDS_PER_CLASS;

	scba_pkg::state_t             state_q, state_d;
	logic [CNT_W-1:0]             count_q [NCLS];
	logic [CNT_W-1:0]             lim [NCLS];
	logic [CLS_W-1:0]             cur_q;
	logic [CLS_W-1:0]             fcls_q;
	logic [IDX_W-1:0]             fidx_q;
	logic [WSEL_W-1:0]            wsel_q;
	logic                         rd_valid_q;
	logic [scba_pkg::RAM_DEPTH-1:0] wvalid_q;
	logic [scba_pkg::RAM_DEPTH-1:0] full_q;

	logic                         m_tvalid_q;
	scba_pkg::status_t            status_q;
	logic [CLS_W-1:0]             gcls_q;
	logic [IDX_W-1:0]             gidx_q;

	// request decode
	logic                         in_xact;
	logic                         req_free;
	logic [scba_pkg::SIZE_W-1:0]  req_size;
	logic [CLS_W-1:0]             start_cls;
	logic                         req_ext;

	// scan and pick datapath
	logic [scba_pkg::NWORD_W-1:0] nwords;
	logic [CNT_W-1:0]             lim_cur;
	logic [WPC-1:0]               word_mask;
	logic [WORD_W-1:0]            scan_vec;
	logic [WORD_W-1:0]            cur_word;
	logic [WORD_W-1:0]            ffs_in;
	scba_pkg::ffs_t               ffs_res;
	logic [IDX_W-1:0]             pick_idx;
	logic                         pick_ok;

	// ram and result controls
	logic                         ram_we;
	logic [RAM_AW-1:0]            ram_waddr;
	logic [WORD_W-1:0]            ram_wdata;
	logic [RAM_AW-1:0]            ram_raddr;
	logic [WORD_W-1:0]            ram_rdata;
	logic                         res_load;
	scba_pkg::status_t            res_status;
	logic [CLS_W-1:0]             res_cls;
	logic [IDX_W-1:0]             res_idx;

	assign s_tready = (state_q == scba_pkg::S_IDLE) && !m_tvalid_q;
	assign in_xact  = s_tvalid && s_tready;
	assign req_free = (s_tuser == scba_pkg::MODE_FREE);
	assign req_size = s_tdata[scba_pkg::SIZE_W-1:0];

	// smallest class whose bound exceeds the size
	always_comb begin
		start_cls = scba_pkg::CLASS_A;
		req_ext   = 1'b0;
		priority if (req_size < scba_pkg::BOUND_A) begin
			start_cls = scba_pkg::CLASS_A;
		end else if (req_size < scba_pkg::BOUND_B) begin
			start_cls = scba_pkg::CLASS_B;
		end else if (req_size < scba_pkg::BOUND_C) begin
			start_cls = scba_pkg::CLASS_C;
		end else if (req_size < scba_pkg::BOUND_D) begin
			start_cls = scba_pkg::CLASS_D;
		end else begin
			req_ext = 1'b1;
		end
	end

	// usable blocks per class
	always_comb begin
		for (int c = 0; c < NCLS; c++) begin
			lim[c] = (count_q[c] > scba_pkg::BLOCK_LIMIT) ? scba_pkg::BLOCK_LIMIT : count_q[c];
		end
	end

	// words of the current class that hold usable blocks
	assign lim_cur = lim[cur_q];
	assign nwords  = scba_pkg::NWORD_W'((lim_cur + CNT_W'(WORD_W - 1)) >> BIT_W);

	always_comb begin
		for (int w = 0; w < WPC; w++) begin
			word_mask[w] = (scba_pkg::NWORD_W'(w) < nwords);
		end
	end

	// summary for the scan: full or unusable words count as set bits
	always_comb begin
		scan_vec          = '1;
		scan_vec[WPC-1:0] = full_q[cur_q*WPC +: WPC] | ~word_mask;
	end

	// unwritten words read as all free
	assign cur_word = rd_valid_q ? ram_rdata : '0;
	assign ffs_in   = (state_q == scba_pkg::S_PICK) ? cur_word : scan_vec;

	scba_ffs u_ffs (
		.vec (ffs_in),
		.res (ffs_res)
	);

	assign pick_idx = {wsel_q, ffs_res.pos};
	assign pick_ok  = ffs_res.found && ({1'b0, pick_idx} < lim_cur);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scba_pkg::S_IDLE: begin
				if (in_xact) begin
					if (req_free) begin
						state_d = scba_pkg::S_FREE_RD;
					end else if (!req_ext) begin
						state_d = scba_pkg::S_SCAN;
					end
				end
			end
			scba_pkg::S_SCAN: begin
				if (ffs_res.found) begin
					state_d = scba_pkg::S_PICK;
				end else if (cur_q == scba_pkg::CLASS_LAST) begin
					state_d = scba_pkg::S_IDLE;
				end
			end
			scba_pkg::S_PICK: begin
				if (pick_ok || (cur_q == scba_pkg::CLASS_LAST)) begin
					state_d = scba_pkg::S_IDLE;
				end else begin
					state_d = scba_pkg::S_SCAN;
				end
			end
			scba_pkg::S_FREE_RD: state_d = scba_pkg::S_FREE_WR;
			scba_pkg::S_FREE_WR: state_d = scba_pkg::S_IDLE;
			default:             state_d = scba_pkg::S_IDLE;
		endcase
	end

	// ram and result controls
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = {cur_q, wsel_q};
		ram_wdata  = cur_word;
		ram_raddr  = {cur_q, ffs_res.pos[WSEL_W-1:0]};
		res_load   = 1'b0;
		res_status = scba_pkg::ST_GRANT;
		res_cls    = '0;
		res_idx    = '0;
		unique case (state_q)
			scba_pkg::S_IDLE: begin
				if (in_xact && !req_free && req_ext) begin
					res_load   = 1'b1;
					res_status = scba_pkg::ST_EXTERNAL;
				end
			end
			scba_pkg::S_SCAN: begin
				if (!ffs_res.found && (cur_q == scba_pkg::CLASS_LAST)) begin
					res_load   = 1'b1;
					res_status = scba_pkg::ST_EXHAUSTED;
				end
			end
			scba_pkg::S_PICK: begin
				if (pick_ok) begin
					ram_we     = 1'b1;
					ram_wdata  = cur_word | (WORD_W'(1) << ffs_res.pos);
					res_load   = 1'b1;
					res_status = scba_pkg::ST_GRANT;
					res_cls    = cur_q;
					res_idx    = pick_idx;
				end else if (cur_q == scba_pkg::CLASS_LAST) begin
					res_load   = 1'b1;
					res_status = scba_pkg::ST_EXHAUSTED;
				end
			end
			scba_pkg::S_FREE_RD: begin
				ram_raddr = {fcls_q, fidx_q[IDX_W-1:BIT_W]};
			end
			scba_pkg::S_FREE_WR: begin
				ram_we     = 1'b1;
				ram_waddr  = {fcls_q, fidx_q[IDX_W-1:BIT_W]};
				ram_wdata  = cur_word & ~(WORD_W'(1) << fidx_q[BIT_W-1:0]);
				res_load   = 1'b1;
				res_status = scba_pkg::ST_FREED;
				res_cls    = fcls_q;
				res_idx    = fidx_q;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	scba_ram #(
		.WIDTH (WORD_W),
		.DEPTH (scba_pkg::RAM_DEPTH)
	) u_flags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// class count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCLS; c++) begin
				count_q[c] <= scba_pkg::COUNT_RESET;
			end
		end else if (cfg_we) begin
			count_q[cfg_index] <= cfg_data;
		end
	end

	// word written and word full bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
			full_q   <= '0;
		end else if (ram_we) begin
			wvalid_q[ram_waddr] <= 1'b1;
			full_q[ram_waddr]   <= &ram_wdata;
		end
	end

	// request and scan working registers
	always_ff @(posedge clk) begin
		if (in_xact) begin
			fcls_q <= s_tdata[33:32];
			fidx_q <= s_tdata[43:34];
			cur_q  <= start_cls;
		end else if ((state_q == scba_pkg::S_SCAN) && !ffs_res.found) begin
			cur_q <= cur_q + CLS_W'(1);
		end else if ((state_q == scba_pkg::S_PICK) && !pick_ok) begin
			cur_q <= cur_q + CLS_W'(1);
		end
		if (state_q == scba_pkg::S_SCAN) begin
			wsel_q <= ffs_res.pos[WSEL_W-1:0];
		end
		rd_valid_q <= wvalid_q[ram_raddr];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q <= res_status;
			gcls_q   <= res_cls;
			gidx_q   <= res_idx;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {{(scba_pkg::OUT_W - CLS_W - IDX_W){1'b0}}, gidx_q, gcls_q};

	// checks
	`SCBA_ASSERT_NEVER(a_busy_while_holding, clk, arst_n, s_tready && m_tvalid_q)
	`SCBA_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_xact, !s_tready)
	`SCBA_ASSERT_IMPLIES(a_pick_has_zero, clk, arst_n, state_q == scba_pkg::S_PICK, ffs_res.found)
	`SCBA_ASSERT_IMPLIES(a_write_state, clk, arst_n, ram_we, (state_q == scba_pkg::S_PICK) || (state_q == scba_pkg::S_FREE_WR))
	`SCBA_ASSERT_IMPLIES(a_grant_in_range, clk, arst_n, m_tvalid_q && (status_q == scba_pkg::ST_GRANT), {1'b0, gidx_q} < lim[gcls_q])

endmodule

[sv/scba_ram.sv]
// ----------------------------------------------------------------------------
// scba_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module scba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/scba_ffs.sv]
// ----------------------------------------------------------------------------
// scba_ffs
// Shared find-first-zero unit: lowest clear bit of a word, searched by byte.
// ----------------------------------------------------------------------------
module scba_ffs (
	input  logic [scba_pkg::WORD_W-1:0] vec,
	output scba_pkg::ffs_t              res
);

	logic [scba_pkg::NGRP-1:0]    grp_zero;
	logic [scba_pkg::NGRP_BW-1:0] grp_sel;
	logic [scba_pkg::GRP_W-1:0]   grp_bits;
	logic [scba_pkg::GRP_BW-1:0]  bit_sel;

	// which byte groups hold a clear bit
	always_comb begin
		for (int g = 0; g < scba_pkg::NGRP; g++) begin
			grp_zero[g] = ~&vec[g*scba_pkg::GRP_W +: scba_pkg::GRP_W];
		end
	end

	// lowest group with a clear bit
	always_comb begin
		grp_sel = '0;
		for (int g = scba_pkg::NGRP - 1; g >= 0; g--) begin
			if (grp_zero[g]) begin
				grp_sel = scba_pkg::NGRP_BW'(g);
			end
		end
	end

	assign grp_bits = vec[grp_sel*scba_pkg::GRP_W +: scba_pkg::GRP_W];

	// lowest clear bit inside that group
	always_comb begin
		bit_sel = '0;
		for (int b = scba_pkg::GRP_W - 1; b >= 0; b--) begin
			if (!grp_bits[b]) begin
				bit_sel = scba_pkg::GRP_BW'(b);
			end
		end
	end

	assign res.found = |grp_zero;
	assign res.pos   = {grp_sel, bit_sel};

endmodule
